FILE: rtl/core/ssdds_pkg.sv
// ----------------------------------------------------------------------------
// ssdds_pkg
// Shared widths, codes and digit helpers for the seven-segment display scan.
// ----------------------------------------------------------------------------
package ssdds_pkg;

  // payload widths
  localparam int VALUE_W = 27;
  localparam int IDX_W   = 3;
  localparam int SEG_W   = 8;
  localparam int POINT_W = 3;
  localparam int EXP_W   = 4;
  localparam int DIGIT_W = 4;

  // decimal digits a full-width value can carry
  localparam int VALUE_DIGITS = 9;

  // default display size
  localparam int DIGIT_COUNT_DEF = 8;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] REG_POINT_DIGIT = APB_ADDR_W'(0);
  localparam logic [POINT_W-1:0]    POINT_RESET     = POINT_W'(6);

  // segment codes
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

  // one digit extraction step
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rem;
  } step_t;

  // power of ten for a digit position
  function automatic logic [63:0] pow10(input logic [EXP_W-1:0] k);
    logic [63:0] p;
    unique case (k)
      4'd0:  p = 64'd1;
      4'd1:  p = 64'd10;
      4'd2:  p = 64'd100;
      4'd3:  p = 64'd1000;
      4'd4:  p = 64'd10000;
      4'd5:  p = 64'd100000;
      4'd6:  p = 64'd1000000;
      4'd7:  p = 64'd10000000;
      4'd8:  p = 64'd100000000;
      4'd9:  p = 64'd1000000000;
      4'd10: p = 64'd10000000000;
      4'd11: p = 64'd100000000000;
      4'd12: p = 64'd1000000000000;
      4'd13: p = 64'd10000000000000;
      4'd14: p = 64'd100000000000000;
      4'd15: p = 64'd1000000000000000;
    endcase
    return p;
  endfunction

  // pick the digit at position k by comparing against its nine multiples
  function automatic step_t digit_step(input logic [VALUE_W-1:0] r,
                                       input logic [EXP_W-1:0]   k);
    logic [63:0] p;
    logic [63:0] mp;
    logic [63:0] sel;
    step_t       s;
    p       = pow10(k);
    sel     = '0;
    mp      = '0;
    s.digit = '0;
    for (int m = 1; m <= 9; m++) begin
      mp = p * 64'(m);
      if (64'(r) >= mp) begin
        s.digit = DIGIT_W'(m);
        sel     = mp;
      end
    end
    s.rem = VALUE_W'(64'(r) - sel);
    return s;
  endfunction

  // common-cathode pattern, segments a-g in bits 0-6
  function automatic logic [SEG_W-1:0] seg_of_digit(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/ssdds_cfg.sv
// ----------------------------------------------------------------------------
// ssdds_cfg
// Register file: holds the decimal-point digit, written over the APB port.
// ----------------------------------------------------------------------------
module ssdds_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssdds_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssdds_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssdds_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  output logic [ssdds_pkg::POINT_W-1:0]    point_digit
);
  import ssdds_pkg::*;

  logic [POINT_W-1:0] point_r;
  logic               wr_en;

  // write transfer in the access phase
  assign wr_en = psel && penable && pwrite && (paddr == REG_POINT_DIGIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= POINT_RESET;
    end else if (wr_en) begin
      point_r <= pwdata[POINT_W-1:0];
    end
  end

  // read back
  always_comb begin
    if (paddr == REG_POINT_DIGIT) begin
      prdata = APB_DATA_W'(point_r);
    end else begin
      prdata = '0;
    end
  end

  assign pready      = 1'b1;
  assign point_digit = point_r;

endmodule

FILE: rtl/core/ssdds_reduce.sv
// ----------------------------------------------------------------------------
// ssdds_reduce
// Input stage: takes a value and strips the decimal digits above the display.
// ----------------------------------------------------------------------------
module ssdds_reduce #(
  parameter int DigitCount = ssdds_pkg::DIGIT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssdds_pkg::VALUE_W-1:0] in_value,
  output logic                          red_valid,
  input  logic                          red_take,
  output logic [ssdds_pkg::VALUE_W-1:0] red_value
);
  import ssdds_pkg::*;

  // digit positions above the display that must be dropped
  localparam int DROP   = (DigitCount < VALUE_DIGITS) ? VALUE_DIGITS - DigitCount : 0;
  localparam int RCNT_W = (DROP > 0) ? $clog2(DROP + 1) : 1;

  logic               hold_r;
  logic [RCNT_W-1:0]  cnt_r;
  logic [VALUE_W-1:0] value_r;
  logic               done;
  logic               in_fire;
  logic [EXP_W-1:0]   exp_cur;
  step_t              step;

  assign done     = hold_r && (cnt_r == '0);
  assign in_stall = hold_r && !(done && red_take);
  assign in_fire  = in_valid && !in_stall;

  // highest remaining position first
  assign exp_cur = EXP_W'(DigitCount - 1) + EXP_W'(cnt_r);
  assign step    = digit_step(value_r, exp_cur);

  // occupancy and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      cnt_r  <= '0;
    end else if (in_fire) begin
      hold_r <= 1'b1;
      cnt_r  <= RCNT_W'(DROP);
    end else if (done && red_take) begin
      hold_r <= 1'b0;
    end else if (hold_r && (cnt_r != '0)) begin
      cnt_r <= cnt_r - RCNT_W'(1);
    end
  end

  // value, reduced one position a cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_r <= in_value;
    end else if (hold_r && (cnt_r != '0)) begin
      value_r <= step.rem;
    end
  end

  assign red_valid = done;
  assign red_value = value_r;

endmodule

FILE: rtl/core/ssdds_digit.sv
// ----------------------------------------------------------------------------
// ssdds_digit
// Digit scanner: one digit a cycle, most significant first, into the
// result register with blanking and decimal point; a held out_stall pauses the scan.
// ----------------------------------------------------------------------------
module ssdds_digit #(
  parameter int DigitCount = ssdds_pkg::DIGIT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          red_valid,
  output logic                          red_take,
  input  logic [ssdds_pkg::VALUE_W-1:0] red_value,
  input  logic [ssdds_pkg::POINT_W-1:0] point_digit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssdds_pkg::IDX_W-1:0]   out_digit_index,
  output logic [ssdds_pkg::SEG_W-1:0]   out_segments,
  output logic                          out_last_digit
);
  import ssdds_pkg::*;

  localparam int POS_W = $clog2(DigitCount);
  localparam int CMP_W = (POS_W > POINT_W) ? POS_W : POINT_W;

  logic               busy_r;
  logic [POS_W-1:0]   pos_r;
  logic               shown_r;
  logic [VALUE_W-1:0] rem_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   idx_r;
  logic [SEG_W-1:0]   seg_r;
  logic               last_r;

  logic               advance;
  logic               is_last;
  logic               take;
  logic [EXP_W-1:0]   exp_cur;
  step_t              step;
  logic               at_point;
  logic               shown_now;
  logic [SEG_W-1:0]   seg_now;

  // scan control
  assign advance  = busy_r && (!out_valid_r || !out_stall);
  assign is_last  = (pos_r == POS_W'(DigitCount - 1));
  assign take     = !busy_r || (advance && is_last);
  assign red_take = take;

  // digit at the current position
  assign exp_cur = EXP_W'(DigitCount - 1) - EXP_W'(pos_r);
  assign step    = digit_step(rem_r, exp_cur);

  // blanking and decimal point
  always_comb begin
    at_point  = (CMP_W'(pos_r) == CMP_W'(point_digit));
    shown_now = shown_r || (step.digit != '0) || at_point;
    seg_now   = shown_now ? seg_of_digit(step.digit) : SEG_BLANK;
    if (at_point) begin
      seg_now = seg_now | SEG_POINT;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pos_r   <= '0;
      shown_r <= 1'b0;
    end else if (take) begin
      busy_r  <= red_valid;
      pos_r   <= '0;
      shown_r <= 1'b0;
    end else if (advance) begin
      pos_r   <= pos_r + POS_W'(1);
      shown_r <= shown_now;
    end
  end

  // remaining value
  always_ff @(posedge clk) begin
    if (take) begin
      rem_r <= red_value;
    end else if (advance) begin
      rem_r <= step.rem;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      idx_r  <= IDX_W'(pos_r);
      seg_r  <= seg_now;
      last_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digit_index = idx_r;
  assign out_segments    = seg_r;
  assign out_last_digit  = last_r;

endmodule

FILE: rtl/core/seven_segment_decimal_display_scan.sv
// ----------------------------------------------------------------------------
// seven_segment_decimal_display_scan
// Splits a binary value into decimal digits and scans out one segment
// pattern per display position, most significant first.
// ----------------------------------------------------------------------------
// Flow: the input stage takes a value and drops the positions above the
//   display, then the digit scanner takes it and emits one position a
//   cycle unless out_stall holds the result register; the input stage can
//   take the next value while the scanner still emits the last one's digits.
// Reset: synchronous active-low rst_n empties both stages and the result
//   register and sets the decimal-point digit to 6.
module seven_segment_decimal_display_scan #(
  parameter int DIGIT_COUNT = ssdds_pkg::DIGIT_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ssdds_pkg::VALUE_W-1:0]    in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ssdds_pkg::IDX_W-1:0]      out_digit_index,
  output logic [ssdds_pkg::SEG_W-1:0]      out_segments,
  output logic                             out_last_digit,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssdds_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssdds_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssdds_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import ssdds_pkg::*;

  logic [POINT_W-1:0] point_digit;
  logic               red_valid;
  logic               red_take;
  logic [VALUE_W-1:0] red_value;

  // configuration registers
  ssdds_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .point_digit (point_digit)
  );

  // input stage, drops digits above the display
  ssdds_reduce #(
    .DigitCount (DIGIT_COUNT)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .red_valid (red_valid),
    .red_take  (red_take),
    .red_value (red_value)
  );

  // digit scanner and result register
  ssdds_digit #(
    .DigitCount (DIGIT_COUNT)
  ) u_digit (
    .clk             (clk),
    .rst_n           (rst_n),
    .red_valid       (red_valid),
    .red_take        (red_take),
    .red_value       (red_value),
    .point_digit     (point_digit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_index (out_digit_index),
    .out_segments    (out_segments),
    .out_last_digit  (out_last_digit)
  );

endmodule

FILE: dv/seven_segment_decimal_display_scan_test.sv
// ----------------------------------------------------------------------------
// seven_segment_decimal_display_scan_test
// Drives binary values into the display scanner and checks every digit
// transfer against an in-bench decimal split with leading-zero blanking and
// decimal point placement, under several point settings and idle patterns.
// ----------------------------------------------------------------------------
module seven_segment_decimal_display_scan_test;

  import ssdds_pkg::*;

  localparam int NUM_DIGITS     = DIGIT_COUNT_DEF;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CHUNKS         = 4;
  localparam int CHUNK_ITEMS    = 36;

  // expected digit transfers and the decimal split that produces them
  class display_scoreboard;
    typedef struct {
      bit [IDX_W-1:0] idx;
      bit [SEG_W-1:0] seg;
      bit             last;
    } digit_t;

    digit_t             digit_q[$];
    bit [POINT_W-1:0]   point_digit;
    int                 errors;
    bit [SEG_W-1:0]     glyph [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                       8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};

    function new();
      point_digit = POINT_RESET;
      errors      = 0;
    endfunction

    function void set_point(bit [POINT_W-1:0] p);
      point_digit = p;
    endfunction

    // split one accepted value into its digit transfers
    function void note_value(bit [VALUE_W-1:0] value);
      int unsigned num;
      int unsigned dig [NUM_DIGITS];
      bit          shown;
      bit          at_point;
      digit_t      d;
      num   = value % 100000000;
      shown = 0;
      for (int pos = NUM_DIGITS - 1; pos >= 0; pos--) begin
        dig[pos] = num % 10;
        num      = num / 10;
      end
      for (int pos = 0; pos < NUM_DIGITS; pos++) begin
        at_point = (pos == point_digit);
        if (dig[pos] != 0 || at_point) shown = 1;
        d.idx  = IDX_W'(pos);
        d.seg  = shown ? glyph[dig[pos]] : SEG_BLANK;
        if (at_point) d.seg = d.seg | SEG_POINT;
        d.last = (pos == NUM_DIGITS - 1);
        digit_q.push_back(d);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    // compare one digit transfer with the oldest expectation
    task check_digit(logic [IDX_W-1:0] idx, logic [SEG_W-1:0] seg, logic last);
      digit_t want;
      if (digit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digit idx %0d seg %h", idx, seg));
        return;
      end
      want = digit_q.pop_front();
      if (idx !== want.idx)
        report_mismatch($sformatf("digit_index %0d, want %0d", idx, want.idx));
      if (seg !== want.seg)
        report_mismatch($sformatf("segments %h, want %h at idx %0d", seg, want.seg,
                                  want.idx));
      if (last !== want.last)
        report_mismatch($sformatf("last_digit %b, want %b at idx %0d", last, want.last,
                                  want.idx));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [VALUE_W-1:0]    in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [IDX_W-1:0]      out_digit_index;
  logic [SEG_W-1:0]      out_segments;
  logic                  out_last_digit;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  display_scoreboard sb = new();
  int                in_idle_pct;
  int                out_stall_pct;
  int                idle_cycles;

  seven_segment_decimal_display_scan u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_index (out_digit_index),
    .out_segments    (out_segments),
    .out_last_digit  (out_last_digit),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall, one decision per falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // digit transfer monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_digit(out_digit_index, out_segments, out_last_digit);
  end

  // watchdog on cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // one value transfer, with random sender gaps
  task automatic send_value(input logic [VALUE_W-1:0] v);
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < in_idle_pct) begin
        in_valid = 1'b0;
        in_value = VALUE_W'($urandom);
      end else begin
        in_valid = 1'b1;
        in_value = v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_value(v);
        done = 1;
      end
    end
  endtask

  // stop sending and wait until every digit has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.digit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_point(input logic [POINT_W-1:0] p);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_POINT_DIGIT;
    pwdata  = {$urandom} & ~APB_DATA_W'(7) | APB_DATA_W'(p);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_point(p);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // random value with a mix of shapes
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned v;
    v = 0;
    case ($urandom_range(0, 5))
      0: v = $urandom & 32'h07ff_ffff;
      1: v = $urandom_range(0, 99999999);
      2: v = $urandom_range(0, 999);
      3: v = $urandom_range(0, 9);
      4: begin
        v = $urandom_range(1, 9);
        repeat ($urandom_range(0, 7)) v = v * 10;
      end
      default: begin
        // digits with many zeros in them
        for (int k = 0; k < NUM_DIGITS; k++)
          v = v * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
      end
    endcase
    return VALUE_W'(v);
  endfunction

  // stimulus
  initial begin
    int unsigned stall_pct_of [3];
    int unsigned idle_pct_of  [3];
    logic [POINT_W-1:0] p;
    stall_pct_of  = '{61, 8, 0};
    idle_pct_of   = '{8, 61, 0};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset point, range extremes, values past eight digits
    send_value(VALUE_W'(0));
    send_value(VALUE_W'(1));
    send_value(VALUE_W'(9));
    send_value(VALUE_W'(10));
    send_value(VALUE_W'(5000000));
    send_value(VALUE_W'(12345678));
    send_value(VALUE_W'(99999999));
    send_value(VALUE_W'(100000000));
    send_value(VALUE_W'(134217727));
    drain();

    // directed: point on the leftmost digit
    write_point(POINT_W'(0));
    send_value(VALUE_W'(0));
    send_value(VALUE_W'(7));
    send_value(VALUE_W'(10203040));
    send_value(VALUE_W'(99999999));
    drain();

    // directed: point on the rightmost digit, blanking over all leading zeros
    write_point(POINT_W'(7));
    send_value(VALUE_W'(0));
    send_value(VALUE_W'(3));
    send_value(VALUE_W'(80000000));
    send_value(VALUE_W'(12345678));
    send_value(VALUE_W'(67108864));
    drain();

    // random phases with different idle patterns and point settings
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct   = idle_pct_of[ph];
      out_stall_pct = stall_pct_of[ph];
      for (int c = 0; c < CHUNKS; c++) begin
        if (c == 0)
          p = POINT_W'(0);
        else if (c == CHUNKS - 1)
          p = POINT_W'(7);
        else
          p = POINT_W'($urandom_range(0, 7));
        write_point(p);
        for (int i = 0; i < CHUNK_ITEMS; i++)
          send_value(pick_value());
        drain();
      end
    end

    // end of run
    if (sb.digit_q.size() != 0)
      sb.report_mismatch($sformatf("%0d digits never came", sb.digit_q.size()));
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: seven_segment_decimal_display_scan.f
rtl/core/ssdds_pkg.sv
rtl/core/ssdds_cfg.sv
rtl/core/ssdds_reduce.sv
rtl/core/ssdds_digit.sv
rtl/core/seven_segment_decimal_display_scan.sv
dv/seven_segment_decimal_display_scan_test.sv
